>>> src/mme_pkg.sv
// Shared constants and register codes for the matrix multiply engine.
package mme_pkg;

    // Default build-time sizes.
    localparam int MAX_DIM_DEF      = 8;
    localparam int ELEMENT_BITS_DEF = 16;

    // Fixed result field widths.
    localparam int VALUE_W   = 35;
    localparam int OUT_IDX_W = 3;

    // Configuration port layout.
    localparam int DIM_REG_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

endpackage

>>> src/mme_if.sv
// Valid/ready channel interfaces for matrix elements and product results.
interface mme_elem_if import mme_pkg::*; #(
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [ELEMENT_BITS-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface mme_result_if import mme_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  product_value;
    logic [OUT_IDX_W-1:0]       out_row;
    logic [OUT_IDX_W-1:0]       out_col;
    logic                       last_result;

    modport source (output valid, output product_value, output out_row,
                    output out_col, output last_result, input ready);
    modport sink   (input valid, input product_value, input out_row,
                    input out_col, input last_result, output ready);
endinterface

>>> src/matrix_multiply_engine.sv
// Loading takes one element word per cycle; the block is ready only while loading.
// Each product word then walks k with one shared multiplier and accumulator behind a
// registered store read and a product register, and the next word starts only after
// the previous one has left.
// Reset (rst_n, asynchronous, active low) sets all dimensions to 8 and clears
// the load position; the element stores are not cleared.
module matrix_multiply_engine import mme_pkg::*; #(
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mme_elem_if.sink             elem_in,
    mme_result_if.source         result_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_REG_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int EXT_W  = (PROD_W > VALUE_W) ? PROD_W : VALUE_W;

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_WAIT  = 2'd1;
    localparam logic [1:0] S_CALC  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    // Configuration registers hold the raw written bits.
    logic [DIM_REG_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;

    // Sequencer and counters.
    logic [1:0]       state_reg, state_next;
    logic             ld_b_reg, ld_b_next;
    logic [IDX_W-1:0] ld_row_reg, ld_row_next, ld_col_reg, ld_col_next;
    logic [IDX_W-1:0] ci_reg, ci_next, cj_reg, cj_next, ck_reg, ck_next;

    // Pipeline tags and data.
    logic                           v1_reg, l1_reg, v2_reg, l2_reg;
    logic signed [ELEMENT_BITS-1:0] a_q_reg, b_q_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [VALUE_W-1:0]      acc_reg;

    // Output register.
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [OUT_IDX_W-1:0]      out_row_reg, out_col_reg;
    logic                      out_last_reg;

    // Element stores.
    logic signed [ELEMENT_BITS-1:0] a_mem [DEPTH];
    logic signed [ELEMENT_BITS-1:0] b_mem [DEPTH];

    logic [DIM_W-1:0]  m_eff, n_eff, q_eff, m_last, n_last, q_last;
    logic [DIM_W-1:0]  ld_col_lim, ld_row_lim;
    logic              in_fire, out_fire, issue, k_end, col_end, row_end;
    logic              final_word, capture;
    logic [ADDR_W-1:0] w_addr, a_raddr, b_raddr;
    logic signed [EXT_W-1:0]   prod_ext;
    logic signed [VALUE_W-1:0] sum;

    // Clamp the raw dimension registers into 1..MAX_DIM.
    always_comb
    begin
        if (rows_a_reg == '0)
            m_eff = DIM_W'(1);
        else if (rows_a_reg > MAX_DIM)
            m_eff = DIM_W'(MAX_DIM);
        else
            m_eff = DIM_W'(rows_a_reg);
        if (inner_dim_reg == '0)
            n_eff = DIM_W'(1);
        else if (inner_dim_reg > MAX_DIM)
            n_eff = DIM_W'(MAX_DIM);
        else
            n_eff = DIM_W'(inner_dim_reg);
        if (cols_b_reg == '0)
            q_eff = DIM_W'(1);
        else if (cols_b_reg > MAX_DIM)
            q_eff = DIM_W'(MAX_DIM);
        else
            q_eff = DIM_W'(cols_b_reg);
    end

    assign m_last = m_eff - DIM_W'(1);
    assign n_last = n_eff - DIM_W'(1);
    assign q_last = q_eff - DIM_W'(1);

    // Handshakes.
    assign elem_in.ready = (state_reg == S_LOAD);
    assign in_fire       = elem_in.valid && elem_in.ready;
    assign out_fire      = out_valid_reg && result_out.ready;

    // Load position: A is rows_a x inner_dim, B is inner_dim x cols_b.
    assign ld_col_lim = ld_b_reg ? q_last : n_last;
    assign ld_row_lim = ld_b_reg ? n_last : m_last;
    assign col_end    = (DIM_W'(ld_col_reg) == ld_col_lim);
    assign row_end    = (DIM_W'(ld_row_reg) == ld_row_lim);
    assign w_addr     = ADDR_W'(ADDR_W'(ld_row_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(ld_col_reg));

    // Compute addresses: A[i][k] and B[k][j].
    assign issue   = (state_reg == S_CALC);
    assign k_end   = (DIM_W'(ck_reg) == n_last);
    assign a_raddr = ADDR_W'(ADDR_W'(ci_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(ck_reg));
    assign b_raddr = ADDR_W'(ADDR_W'(ck_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(cj_reg));

    // Accumulate the registered product into the low bits of the sum.
    assign prod_ext   = EXT_W'(prod_reg);
    assign sum        = acc_reg + prod_ext[VALUE_W-1:0];
    assign capture    = v2_reg && l2_reg;
    assign final_word = (DIM_W'(ci_reg) == m_last) && (DIM_W'(cj_reg) == q_last);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next  = state_reg;
        ld_b_next   = ld_b_reg;
        ld_row_next = ld_row_reg;
        ld_col_next = ld_col_reg;
        ci_next     = ci_reg;
        cj_next     = cj_reg;
        ck_next     = ck_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (col_end)
                    begin
                        ld_col_next = '0;
                        if (row_end)
                        begin
                            ld_row_next = '0;
                            if (ld_b_reg)
                            begin
                                ld_b_next  = 1'b0;
                                ci_next    = '0;
                                cj_next    = '0;
                                ck_next    = '0;
                                state_next = S_WAIT;
                            end
                            else
                            begin
                                ld_b_next = 1'b1;
                            end
                        end
                        else
                        begin
                            ld_row_next = ld_row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ld_col_next = ld_col_reg + 1'b1;
                    end
                end
                if (cfg_we)
                begin
                    ld_b_next   = 1'b0;
                    ld_row_next = '0;
                    ld_col_next = '0;
                end
            end
            S_WAIT:
            begin
                if (!out_valid_reg)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                if (k_end)
                begin
                    ck_next    = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    ck_next = ck_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (capture)
                begin
                    if (final_word)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_WAIT;
                        if (DIM_W'(cj_reg) == q_last)
                        begin
                            cj_next = '0;
                            ci_next = ci_reg + 1'b1;
                        end
                        else
                        begin
                            cj_next = cj_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
            state_reg     <= S_LOAD;
            ld_b_reg      <= 1'b0;
            ld_row_reg    <= '0;
            ld_col_reg    <= '0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            ck_reg        <= '0;
            v1_reg        <= 1'b0;
            l1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            l2_reg        <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                    CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                    CFG_COLS_B:    cols_b_reg    <= cfg_data;
                    default:       ;
                endcase
            end
            state_reg  <= state_next;
            ld_b_reg   <= ld_b_next;
            ld_row_reg <= ld_row_next;
            ld_col_reg <= ld_col_next;
            ci_reg     <= ci_next;
            cj_reg     <= cj_next;
            ck_reg     <= ck_next;
            v1_reg     <= issue;
            l1_reg     <= issue && k_end;
            v2_reg     <= v1_reg;
            l2_reg     <= l1_reg;
            if (v2_reg)
                acc_reg <= l2_reg ? '0 : sum;
            if (capture)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // Store writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (in_fire && !ld_b_reg)
            a_mem[w_addr] <= elem_in.element;
        if (in_fire && ld_b_reg)
            b_mem[w_addr] <= elem_in.element;
        a_q_reg <= a_mem[a_raddr];
        b_q_reg <= b_mem[b_raddr];
    end

    // Shared multiplier and result payload.
    always_ff @(posedge clk)
    begin
        prod_reg <= a_q_reg * b_q_reg;
        if (capture)
        begin
            out_value_reg <= sum;
            out_row_reg   <= OUT_IDX_W'(ci_reg);
            out_col_reg   <= OUT_IDX_W'(cj_reg);
            out_last_reg  <= final_word;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.product_value = out_value_reg;
    assign result_out.out_row       = out_row_reg;
    assign result_out.out_col       = out_col_reg;
    assign result_out.last_result   = out_last_reg;

endmodule

>>> src/mme_checker.sv
// Port-level checks for the matrix multiply engine, bound to the top level.
module mme_checker import mme_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 last_result,
    input logic [OUT_IDX_W-1:0] out_row,
    input logic [OUT_IDX_W-1:0] out_col
);

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result word keeps its position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_row) && $stable(out_col))
        else $error("result position changed while stalled");

    // No element is taken while a non-final result word is still offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> !in_ready)
        else $error("input ready during product output");

    // After a non-final word leaves, the next word is computed, not a load.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_result |=> !in_ready)
        else $error("input ready before product finished");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (elem_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .last_result (result_out.last_result),
    .out_row     (result_out.out_row),
    .out_col     (result_out.out_col)
);
